// ===== src/iqu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqu_pkg: shared types and constants of the word-aligned I/Q unpacker
// Item layouts, configuration register map and field widths.
// ----------------------------------------------------------------------------
package iqu_pkg;

    // field widths
    localparam int HALF_W     = 16;
    localparam int SAMPLE_W   = 12;
    localparam int MARKER_BIT = 12;
    localparam int PKT_LEN_W  = 17;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 17;
    localparam int S_TDATA_W  = 2 * HALF_W;
    localparam int M_TDATA_W  = 2 * SAMPLE_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_START    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_SAMPLES = 8'd1;

    // reset values of the configuration registers
    localparam logic                 FRAME_START_RST    = 1'b0;
    localparam logic [PKT_LEN_W-1:0] PACKET_SAMPLES_RST = 17'd4096;

    typedef struct packed {
        logic                 frame_start;
        logic [PKT_LEN_W-1:0] packet_samples;
    } t_cfg;

    typedef struct packed {
        logic              buffer_first;
        logic [HALF_W-1:0] high_half;
        logic [HALF_W-1:0] low_half;
    } t_in_item;

    typedef struct packed {
        logic                       packet_last;
        logic signed [SAMPLE_W-1:0] q_sample;
        logic signed [SAMPLE_W-1:0] i_sample;
    } t_out_item;

endpackage

// ===== src/iqu_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqu_cfg_regs: configuration registers
// Holds frame start polarity and packet length; writes to unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module iqu_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [iqu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [iqu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output iqu_pkg::t_cfg                 o_cfg
);
    import iqu_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // always ready for a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register index decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_START:    n_cfg.frame_start    = i_cfg_data[0];
                CFG_PACKET_SAMPLES: n_cfg.packet_samples = i_cfg_data[PKT_LEN_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_start    <= FRAME_START_RST;
            r_cfg.packet_samples <= PACKET_SAMPLES_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/iqu_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqu_in_stage: input register
// Captures one sample word per cycle while it is empty or the held item is
// taken; refills in the same cycle that the held item moves on.
// ----------------------------------------------------------------------------
module iqu_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  iqu_pkg::t_in_item i_item,
    output logic              o_valid,
    output iqu_pkg::t_in_item o_item,
    input  logic              i_take
);
    import iqu_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // free when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== src/iqu_unpack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqu_unpack: alignment, sample split, packet marking and result register
// Decides alignment on the first word of a buffer, forms one I/Q pair per
// word and marks the pair that closes a packet.
// ----------------------------------------------------------------------------
module iqu_unpack #(
    parameter int MAX_PACKET_PAIRS = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iqu_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    input  iqu_pkg::t_in_item  i_item,
    output logic               o_take,
    output logic               o_valid,
    input  logic               i_ready,
    output iqu_pkg::t_out_item o_result
);
    import iqu_pkg::*;

    localparam int                   CNT_W   = (MAX_PACKET_PAIRS > 1) ?
                                               $clog2(MAX_PACKET_PAIRS) : 1;
    localparam logic [PKT_LEN_W-1:0] MAX_LEN = PKT_LEN_W'(MAX_PACKET_PAIRS);

    logic                r_out_valid;
    t_out_item           r_out;
    logic                r_misaligned;
    logic [SAMPLE_W-1:0] r_held_i;
    logic [CNT_W-1:0]    r_count;

    logic                n_misaligned;
    logic [SAMPLE_W-1:0] n_held_i;
    logic [CNT_W-1:0]    n_count;
    t_out_item           n_out;
    logic [PKT_LEN_W-1:0] len_eff;
    logic [PKT_LEN_W-1:0] cnt_inc;
    logic                pkt_last;

    // item moves from the input register into the result register
    assign o_take   = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // alignment and sample split
    always_comb begin
        n_misaligned = r_misaligned;
        if (i_item.buffer_first) begin
            n_misaligned = (i_item.low_half[MARKER_BIT] == i_cfg.frame_start);
        end
        n_held_i = r_held_i;
        if (n_misaligned) begin
            n_out.i_sample = r_held_i;
            n_out.q_sample = i_item.low_half[SAMPLE_W-1:0];
            n_held_i       = i_item.high_half[SAMPLE_W-1:0];
        end else begin
            n_out.i_sample = i_item.low_half[SAMPLE_W-1:0];
            n_out.q_sample = i_item.high_half[SAMPLE_W-1:0];
        end
        n_out.packet_last = pkt_last;
    end

    // packet length clamp and pair counter
    always_comb begin
        if (i_cfg.packet_samples == '0) begin
            len_eff = PKT_LEN_W'(1);
        end else if (i_cfg.packet_samples > MAX_LEN) begin
            len_eff = MAX_LEN;
        end else begin
            len_eff = i_cfg.packet_samples;
        end
        cnt_inc  = PKT_LEN_W'(r_count) + PKT_LEN_W'(1);
        pkt_last = (cnt_inc >= len_eff);
        n_count  = pkt_last ? '0 : cnt_inc[CNT_W-1:0];
    end

    // control and item state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_misaligned <= 1'b0;
            r_held_i     <= '0;
            r_count      <= '0;
        end else if (o_take) begin
            r_out_valid  <= 1'b1;
            r_misaligned <= n_misaligned;
            r_held_i     <= n_held_i;
            r_count      <= n_count;
        end else if (i_ready) begin
            r_out_valid  <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    // a marked pair restarts the count
    a_last_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && n_out.packet_last |=> r_count == '0)
        else $error("pair count not cleared after last pair");

    // count moves only when an item is taken
    a_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_take |=> $stable(r_count) && $stable(r_held_i))
        else $error("unpack state changed without an item");

    // aligned words leave the held I alone
    a_aligned_keeps_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && !n_misaligned |=> r_held_i == $past(r_held_i))
        else $error("held I changed on an aligned word");

    // a waiting result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |-> !o_take)
        else $error("result register overwritten while stalled");

endmodule

// ===== src/iq_unpack_word_aligned_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_unpack_word_aligned_top: word-aligned I/Q unpacker
// Splits 32-bit sample words into signed 12-bit I/Q pairs, with
// alignment taken from the frame marker and packet end marking.
// ----------------------------------------------------------------------------
// a word accepted into the input register moves on into the result register and out on m_axis
// throughput: one word per cycle while m_axis is not stalled, set by the input register and result
// register each moving one item per cycle; a stall holds one result plus one input word
// reset: synchronous active low; clears valids, pair count, alignment, held I
// and loads frame_start = 0, packet_samples = 4096
// ----------------------------------------------------------------------------
module iq_unpack_word_aligned_top #(
    parameter int MAX_PACKET_PAIRS = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [iqu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [iqu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [iqu_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // low_half[15:0], high_half[31:16]
    input  logic                           s_axis_tuser,  // buffer_first
    // output pairs
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [iqu_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // i_sample[11:0], q_sample[23:12]
    output logic                           m_axis_tlast   // packet_last
);
    import iqu_pkg::*;

    t_cfg      cfg;
    t_in_item  s_item;
    t_in_item  held_item;
    t_out_item result;
    logic      held_valid;
    logic      take;

    // input packing
    assign s_item.low_half     = s_axis_tdata[HALF_W-1:0];
    assign s_item.high_half    = s_axis_tdata[S_TDATA_W-1:HALF_W];
    assign s_item.buffer_first = s_axis_tuser;

    iqu_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    iqu_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (s_item),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (take)
    );

    iqu_unpack #(
        .MAX_PACKET_PAIRS (MAX_PACKET_PAIRS)
    ) u_unpack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (held_valid),
        .i_item   (held_item),
        .o_take   (take),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // output packing
    assign m_axis_tdata = {result.q_sample, result.i_sample};
    assign m_axis_tlast = result.packet_last;

endmodule
